// ===== design/subarray_gcd_counter_defines.svh =====
// Assertion macros for the checker file of the subarray gcd counter.
`ifndef SUBARRAY_GCD_COUNTER_DEFINES_SVH
`define SUBARRAY_GCD_COUNTER_DEFINES_SVH

// Antecedent in one cycle, consequent in the next.
`define SGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Antecedent and consequent in the same cycle.
`define SGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/sgc_pkg.sv =====
// Types, constants and codes of the subarray gcd counter.
package sgc_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int NUM_QUERIES  = 16;
    localparam int VALUE_BITS   = 31;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 31;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 48;

    // One spare cell holds the segment that may fall off after merging.
    localparam int NCELL = MAX_SEGMENTS + 1;
    localparam int ROT_W = $clog2(NCELL);
    localparam int K_W   = $clog2(VALUE_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CLEAR,
        CMD_INSERT,
        CMD_GLOAD,
        CMD_GSTEP,
        CMD_MERGE,
        CMD_DROP,
        CMD_ROTATE
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_GLOAD,
        ST_GRUN,
        ST_MERGE,
        ST_DROP,
        ST_COUNT
    } t_state;

    typedef struct packed {
        t_cell_op               op;
        logic [VALUE_BITS-1:0]  x;
    } t_cell_cmd;

    typedef struct packed {
        logic                   valid;
        logic [VALUE_BITS-1:0]  g;
        logic [LEN_W-1:0]       len;
    } t_seg;

endpackage

// ===== design/subarray_gcd_counter.sv =====
// Top level of the subarray gcd counter: op decode, query slots and the cell chain.
//
//   channel | valid   | stall   | payload
//   in      | i_valid | o_stall | i_op, i_slot, i_value
//   out     | o_valid | i_stall | o_slot_out, o_count
//
// Load, read and clear leave the block idle.
// A push stalls the input while it runs: insert, gcd start, binary gcd steps in all
// cells at once (the slowest cell sets the length) until all are seen done, one merge
// per cycle until none is left, tail drop, then one full rotation of the chain past
// the query comparators.
// Reset clears the chain, the loaded flags, the counters and the output valid flag.
// A read beat is taken while an earlier result waits unless that result is stalled.
module subarray_gcd_counter import sgc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [SLOT_W-1:0]  o_slot_out,
    output logic [COUNT_W-1:0] o_count
);

    t_state                r_state;
    t_state                n_state;
    logic [VALUE_BITS-1:0] r_x;
    logic [ROT_W-1:0]      r_rot;
    logic [ROT_W-1:0]      n_rot;
    t_cell_cmd             cmd;

    logic [VALUE_BITS-1:0] r_qval  [NUM_QUERIES];
    logic                  r_qload [NUM_QUERIES];
    logic [COUNT_W-1:0]    r_qcnt  [NUM_QUERIES];

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [COUNT_W-1:0]    r_out_count;

    t_seg                  seg   [NCELL];
    logic                  dup   [NCELL];
    logic                  found [NCELL+1];
    logic [NCELL-1:0]      done;

    logic                  accept;
    logic [COUNT_W-1:0]    read_count;
    logic [VALUE_BITS-1:0] in_x;

    assign in_x = i_value[VALUE_BITS-1:0];

    // Hold input while busy, and hold a read while its result register is blocked.
    assign o_stall = (r_state != ST_IDLE)
                   || ((t_op'(i_op) == OP_READ) && r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign o_valid    = r_out_valid;
    assign o_slot_out = r_out_slot;
    assign o_count    = r_out_count;

    // Cell chain: each cell sees its neighbors; the tail wraps to the head for rotation.
    assign found[0] = 1'b0;
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        t_seg prev_seg;
        t_seg next_seg;
        logic next_dup;

        if (c == 0) begin : g_head
            assign prev_seg = '0;
        end else begin : g_body
            assign prev_seg = seg[c-1];
        end
        if (c == NCELL - 1) begin : g_tail
            assign next_seg = seg[0];
            assign next_dup = 1'b0;
        end else begin : g_mid
            assign next_seg = seg[c+1];
            assign next_dup = dup[c+1];
        end

        sgc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_head     (c == 0),
            .i_tail     (c == NCELL - 1),
            .i_cmd      (cmd),
            .i_prev     (prev_seg),
            .i_next     (next_seg),
            .i_next_dup (next_dup),
            .i_found    (found[c]),
            .o_seg      (seg[c]),
            .o_dup      (dup[c]),
            .o_found    (found[c+1]),
            .o_done     (done[c])
        );
    end

    // Sequencer for a push.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rot   <= '0;
        end else begin
            r_state <= n_state;
            r_rot   <= n_rot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rot   = r_rot;
        cmd.op  = CMD_HOLD;
        cmd.x   = r_x;
        case (r_state)
            ST_IDLE: begin
                if (accept && t_op'(i_op) == OP_PUSH) begin
                    n_state = ST_INSERT;
                end
                if (accept && t_op'(i_op) == OP_CLEAR) begin
                    cmd.op = CMD_CLEAR;
                end
            end
            ST_INSERT: begin
                cmd.op  = CMD_INSERT;
                n_state = ST_GLOAD;
            end
            ST_GLOAD: begin
                cmd.op  = CMD_GLOAD;
                n_state = ST_GRUN;
            end
            ST_GRUN: begin
                if (&done) begin
                    n_state = ST_MERGE;
                end else begin
                    cmd.op = CMD_GSTEP;
                end
            end
            ST_MERGE: begin
                // Fold one pair of equal neighbors per cycle until none is left.
                if (found[NCELL]) begin
                    cmd.op = CMD_MERGE;
                end else begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                cmd.op  = CMD_DROP;
                n_rot   = '0;
                n_state = ST_COUNT;
            end
            ST_COUNT: begin
                // Rotate every cell past the head once; the chain ends where it began.
                cmd.op = CMD_ROTATE;
                n_rot  = r_rot + ROT_W'(1);
                if (r_rot == ROT_W'(NCELL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_op) == OP_PUSH) begin
            r_x <= in_x;
        end
    end

    // Query slots and their counters.
    always_ff @(posedge i_clk) begin
        logic [COUNT_W:0] sum;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_QUERIES; k++) begin
                r_qload[k] <= 1'b0;
                r_qcnt[k]  <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_QUERIES; k++) begin
                sum = {1'b0, r_qcnt[k]} + (COUNT_W + 1)'(seg[0].len);
                if (accept && t_op'(i_op) == OP_CLEAR) begin
                    r_qload[k] <= 1'b0;
                    r_qcnt[k]  <= '0;
                end else if (accept && t_op'(i_op) == OP_LOAD && int'(i_slot) == k) begin
                    r_qval[k]  <= in_x;
                    r_qload[k] <= 1'b1;
                    r_qcnt[k]  <= '0;
                end else if (r_state == ST_COUNT && seg[0].valid && r_qload[k]
                             && seg[0].g == r_qval[k]) begin
                    r_qcnt[k] <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                end
            end
        end
    end

    // Unloaded slots and slots past the table read as zero.
    always_comb begin
        read_count = '0;
        for (int k = 0; k < NUM_QUERIES; k++) begin
            if (int'(i_slot) == k && r_qload[k]) begin
                read_count = r_qcnt[k];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && t_op'(i_op) == OP_READ) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_op) == OP_READ) begin
            r_out_slot  <= i_slot;
            r_out_count <= read_count;
        end
    end

endmodule

// ===== design/sgc_cell.sv =====
// One segment cell: holds a (gcd, length) pair and runs its own binary gcd.
module sgc_cell import sgc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head,
    input  logic      i_tail,
    input  t_cell_cmd i_cmd,
    input  t_seg      i_prev,
    input  t_seg      i_next,
    input  logic      i_next_dup,
    input  logic      i_found,
    output t_seg      o_seg,
    output logic      o_dup,
    output logic      o_found,
    output logic      o_done
);

    t_seg                  r_seg;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_b;
    logic [K_W-1:0]        r_k;
    logic                  r_done;
    logic [LEN_W:0]        merge_sum;

    assign o_seg   = r_seg;
    assign o_done  = r_done;
    assign o_dup   = !i_head && r_seg.valid && i_prev.valid && (r_seg.g == i_prev.g);
    assign o_found = i_found | o_dup;
    assign merge_sum = {1'b0, r_seg.len} + {1'b0, i_next.len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
            r_done      <= 1'b1;
        end else begin
            case (i_cmd.op)
                CMD_CLEAR: begin
                    r_seg.valid <= 1'b0;
                end
                CMD_INSERT: begin
                    if (i_head) begin
                        r_seg.valid <= 1'b1;
                        r_seg.g     <= i_cmd.x;
                        r_seg.len   <= LEN_W'(1);
                    end else begin
                        r_seg <= i_prev;
                    end
                end
                CMD_GLOAD: begin
                    r_a    <= r_seg.g;
                    r_b    <= i_cmd.x;
                    r_k    <= '0;
                    r_done <= !r_seg.valid;
                end
                CMD_GSTEP: begin
                    if (!r_done) begin
                        if (r_a == '0 || r_b == '0) begin
                            r_seg.g <= (r_a | r_b) << r_k;
                            r_done  <= 1'b1;
                        end else if (!r_a[0] && !r_b[0]) begin
                            r_a <= r_a >> 1;
                            r_b <= r_b >> 1;
                            r_k <= r_k + K_W'(1);
                        end else if (!r_a[0]) begin
                            r_a <= r_a >> 1;
                        end else if (!r_b[0]) begin
                            r_b <= r_b >> 1;
                        end else if (r_a >= r_b) begin
                            r_a <= (r_a - r_b) >> 1;
                        end else begin
                            r_b <= (r_b - r_a) >> 1;
                        end
                    end
                end
                CMD_MERGE: begin
                    // Cells from the first duplicate on move down one place.
                    if (o_found) begin
                        if (i_tail) begin
                            r_seg.valid <= 1'b0;
                        end else begin
                            r_seg <= i_next;
                        end
                    end else if (i_next_dup) begin
                        r_seg.len <= merge_sum[LEN_W] ? '1 : merge_sum[LEN_W-1:0];
                    end
                end
                CMD_DROP: begin
                    if (i_tail) begin
                        r_seg.valid <= 1'b0;
                    end
                end
                CMD_ROTATE: begin
                    r_seg <= i_next;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/sgc_checker.sv =====
// Port-level checker for the subarray gcd counter, bound to the top level.
`include "subarray_gcd_counter_defines.svh"

module sgc_checker import sgc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [OP_W-1:0]    i_op,
    input logic [SLOT_W-1:0]  i_slot,
    input logic [VALUE_W-1:0] i_value,
    input logic               o_valid,
    input logic               i_stall,
    input logic [SLOT_W-1:0]  o_slot_out,
    input logic [COUNT_W-1:0] o_count
);

    `SGC_ASSERT_NEXT(a_push_busy, i_valid && !o_stall && i_op == OP_PUSH, o_stall, "push beat did not make the block busy")
    `SGC_ASSERT_NEXT(a_read_result, i_valid && !o_stall && i_op == OP_READ, o_valid && o_slot_out == $past(i_slot), "read beat gave no matching result")
    `SGC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_slot_out) && $stable(o_count), "stalled result changed")
    `SGC_ASSERT_NEXT(a_clear_zero, i_valid && !o_stall && i_op == OP_CLEAR ##1 i_valid && !o_stall && i_op == OP_READ, o_count == '0, "count not cleared by new sequence")

endmodule

bind subarray_gcd_counter sgc_checker u_sgc_checker (.*);
